>>> hdl/fern_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Barnsley fern point generator.
// Used by fern_front, fern_back and ifs_fern_point_generator; depends on nothing.
package fern_pkg;

  // Fixed-point format of the stored point: 5 integer bits, FRAC_BITS fraction bits.
  localparam int FRAC_BITS = 16;
  localparam int POINT_W   = FRAC_BITS + 5;
  localparam int COEF_W    = 18;

  // Configuration register layout.
  localparam int SIDE_W  = 13;
  localparam int INDEX_W = 1;
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [SIDE_W-1:0]  WIDTH_RESET      = 13'd640;
  localparam logic [SIDE_W-1:0]  HEIGHT_RESET     = 13'd480;
  localparam logic [SIDE_W-1:0]  MAX_SIDE         = 13'd4096;

  // Field widths of one item.
  localparam int PICK_W  = 7;
  localparam int PIXEL_W = 12;

  // The four affine maps of the fern.
  typedef enum logic [1:0] {
    MAP_STEM  = 2'd0,
    MAP_LEFT  = 2'd1,
    MAP_RIGHT = 2'd2,
    MAP_MAIN  = 2'd3
  } map_t;

  // Head of the map queue as seen by the back end.
  typedef struct packed {
    logic valid;
    map_t map;
  } pick_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SCALE,
    ST_DIV,
    ST_PLACE
  } back_state_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Map coefficients k/100 in Q.16, rounded to nearest with ties away from zero.
  // New x = a*x + b*y + e, new y = c*x + d*y + f.
  localparam coef_t MAP_A [4] = '{ 18'sd0,     18'sd13107, -18'sd9830, 18'sd55706 };
  localparam coef_t MAP_B [4] = '{ 18'sd0,    -18'sd17039,  18'sd18350, 18'sd2621 };
  localparam coef_t MAP_C [4] = '{ 18'sd0,     18'sd15073,  18'sd17039, -18'sd2621 };
  localparam coef_t MAP_D [4] = '{ 18'sd10486, 18'sd14418,  18'sd15729, 18'sd55706 };
  localparam coef_t MAP_E [4] = '{ 18'sd0,     18'sd0,      18'sd0,     18'sd0 };
  localparam coef_t MAP_F [4] = '{ 18'sd0,     18'sd104858, 18'sd28836, 18'sd104858 };

  // Pixel scaling: x divides by 11 * 2^16 and y by 101 * 2^16.
  localparam logic signed [23:0] X_BIAS = 24'sd720896;    // 11 * 2^16
  localparam logic signed [25:0] Y_BIAS = 26'sd6619136;   // 101 * 2^16
  // Reciprocals: q = (n * RECIP) >> SHIFT, exact over the reachable range of n.
  localparam logic [18:0] RECIP_11  = 19'd381301;         // ceil(2^22 / 11)
  localparam logic [21:0] RECIP_101 = 22'd2657777;        // ceil(2^28 / 101)

endpackage

>>> hdl/fern_front.sv
`timescale 1ns / 1ps
// Front end: accepts random picks, classifies each into a map index and
// queues it for the back end. Depends on fern_pkg.
module fern_front #(
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pick_valid,
  output logic                         pick_stall,
  input  logic [fern_pkg::PICK_W-1:0]  random_pick,
  output fern_pkg::pick_t              head,
  input  logic                         pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fern_pkg::map_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  fern_pkg::map_t   pick_map;
  logic             push;

  // Weights 1, 7, 7, 85; everything from 15 up is the main map.
  always_comb begin
    if (random_pick == 7'd0) begin
      pick_map = fern_pkg::MAP_STEM;
    end else if (random_pick inside {[7'd1:7'd7]}) begin
      pick_map = fern_pkg::MAP_LEFT;
    end else if (random_pick inside {[7'd8:7'd14]}) begin
      pick_map = fern_pkg::MAP_RIGHT;
    end else begin
      pick_map = fern_pkg::MAP_MAIN;
    end
  end

  assign pick_stall = (count == CNT_W'(DEPTH));
  assign push       = pick_valid && !pick_stall;
  assign head.valid = (count != '0);
  assign head.map   = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= pick_map;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/fern_back.sv
`timescale 1ns / 1ps
// Back end: applies the chosen affine map to the stored point and scales the
// new point to a clamped pixel in an output register. Depends on fern_pkg.
module fern_back (
  input  logic                              clk,
  input  logic                              rst,
  input  fern_pkg::pick_t                   head,
  output logic                              pop,
  input  logic [fern_pkg::SIDE_W-1:0]       image_width,
  input  logic [fern_pkg::SIDE_W-1:0]       image_height,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output logic [fern_pkg::PIXEL_W-1:0]      pixel_x,
  output logic [fern_pkg::PIXEL_W-1:0]      pixel_y,
  output logic                              in_bounds
);

  localparam int PW = fern_pkg::POINT_W;
  localparam int MW = fern_pkg::POINT_W + fern_pkg::COEF_W;

  fern_pkg::back_state_t state, state_next;
  fern_pkg::map_t        sel;

  logic signed [PW-1:0] point_x;
  logic signed [PW-1:0] point_y;
  logic signed [MW-1:0] prod_ax, prod_by, prod_cx, prod_dy;
  logic signed [36:0]   num_x;
  logic signed [39:0]   num_y;
  logic [13:0]          q_x, q_y;
  logic                 low_x, low_y;

  logic                 slot_free;
  logic                 place;
  logic [12:0]          w_eff, h_eff;

  logic signed [MW:0]   sum_x, sum_y;
  logic signed [PW-1:0] new_x, new_y;
  logic signed [23:0]   t_x;
  logic signed [25:0]   t_y;
  logic [17:0]          n_x;
  logic [20:0]          n_y;
  logic [36:0]          r_x;
  logic [42:0]          r_y;

  // Round Q.32 to Q.16 (ties up), add the offset and saturate to the point range.
  function automatic logic signed [PW-1:0] next_coord(
    input logic signed [MW:0]               sum,
    input logic signed [fern_pkg::COEF_W-1:0] offset
  );
    logic signed [MW:0]                      rnd;
    logic signed [MW-fern_pkg::FRAC_BITS:0]  sh;
    logic signed [MW-fern_pkg::FRAC_BITS+1:0] v;
    rnd = sum + (MW+1)'(1 << (fern_pkg::FRAC_BITS - 1));
    sh  = rnd[MW:fern_pkg::FRAC_BITS];
    v   = (MW - fern_pkg::FRAC_BITS + 2)'(sh) + (MW - fern_pkg::FRAC_BITS + 2)'(offset);
    if (v > (MW - fern_pkg::FRAC_BITS + 2)'((1 << (PW - 1)) - 1)) begin
      next_coord = {1'b0, {(PW-1){1'b1}}};
    end else if (v < -(MW - fern_pkg::FRAC_BITS + 2)'(1 << (PW - 1))) begin
      next_coord = {1'b1, {(PW-1){1'b0}}};
    end else begin
      next_coord = v[PW-1:0];
    end
  endfunction

  // A zero size acts as one and an oversized one as the maximum.
  always_comb begin
    w_eff = image_width;
    if (image_width == '0) w_eff = 13'd1;
    else if (image_width > fern_pkg::MAX_SIDE) w_eff = fern_pkg::MAX_SIDE;
    h_eff = image_height;
    if (image_height == '0) h_eff = 13'd1;
    else if (image_height > fern_pkg::MAX_SIDE) h_eff = fern_pkg::MAX_SIDE;
  end

  assign slot_free = !pixel_valid || !pixel_stall;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fern_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state; the next item is taken as the current one is placed.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    place      = 1'b0;
    case (state)
      fern_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = fern_pkg::ST_MUL;
        end
      end
      fern_pkg::ST_MUL:   state_next = fern_pkg::ST_ADD;
      fern_pkg::ST_ADD:   state_next = fern_pkg::ST_SCALE;
      fern_pkg::ST_SCALE: state_next = fern_pkg::ST_DIV;
      fern_pkg::ST_DIV:   state_next = fern_pkg::ST_PLACE;
      fern_pkg::ST_PLACE: begin
        if (slot_free) begin
          place = 1'b1;
          if (head.valid) begin
            pop        = 1'b1;
            state_next = fern_pkg::ST_MUL;
          end else begin
            state_next = fern_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = fern_pkg::ST_IDLE;
    endcase
  end

  // Map update arithmetic.
  always_comb begin
    sum_x = (MW+1)'(prod_ax) + (MW+1)'(prod_by);
    sum_y = (MW+1)'(prod_cx) + (MW+1)'(prod_dy);
    new_x = next_coord(sum_x, fern_pkg::MAP_E[sel]);
    new_y = next_coord(sum_y, fern_pkg::MAP_F[sel]);
  end

  // Scaling terms: 11*2^16 + 4*px and 101*2^16 - 10*py.
  always_comb begin
    t_x = fern_pkg::X_BIAS + 24'(point_x) * 24'sd4;
    t_y = fern_pkg::Y_BIAS - 26'(point_y) * 26'sd10;
  end

  // Floor by 2^16, then divide by 11 and 101 through reciprocals.
  always_comb begin
    n_x = num_x[36] ? '0 : num_x[33:16];
    n_y = num_y[39] ? '0 : num_y[36:16];
    r_x = 37'(n_x) * 37'(fern_pkg::RECIP_11);
    r_y = 43'(n_y) * 43'(fern_pkg::RECIP_101);
  end

  // Stored point; reset puts it at the origin.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= '0;
      point_y <= '0;
    end else if (state == fern_pkg::ST_ADD) begin
      point_x <= new_x;
      point_y <= new_y;
    end
  end

  // Datapath pipeline registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      sel <= head.map;
    end
    if (state == fern_pkg::ST_MUL) begin
      prod_ax <= MW'(fern_pkg::MAP_A[sel]) * MW'(point_x);
      prod_by <= MW'(fern_pkg::MAP_B[sel]) * MW'(point_y);
      prod_cx <= MW'(fern_pkg::MAP_C[sel]) * MW'(point_x);
      prod_dy <= MW'(fern_pkg::MAP_D[sel]) * MW'(point_y);
    end
    if (state == fern_pkg::ST_SCALE) begin
      num_x <= 37'($signed({1'b0, w_eff[12:1]})) * 37'(t_x);
      num_y <= 40'($signed({1'b0, h_eff})) * 40'(t_y);
    end
    if (state == fern_pkg::ST_DIV) begin
      // Truncation toward zero goes negative only at or below minus one divisor.
      low_x <= (num_x <= -37'(fern_pkg::X_BIAS));
      low_y <= (num_y <= -40'(fern_pkg::Y_BIAS));
      q_x   <= r_x[35:22];
      q_y   <= r_y[41:28];
    end
  end

  // Output register with clamping to the image.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (place) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      if (low_x) begin
        pixel_x <= '0;
      end else if (q_x >= 14'(w_eff)) begin
        pixel_x <= 12'(w_eff - 13'd1);
      end else begin
        pixel_x <= q_x[11:0];
      end
      if (low_y) begin
        pixel_y <= '0;
      end else if (q_y >= 14'(h_eff)) begin
        pixel_y <= 12'(h_eff - 13'd1);
      end else begin
        pixel_y <= q_y[11:0];
      end
      in_bounds <= !low_x && (q_x < 14'(w_eff)) && !low_y && (q_y < 14'(h_eff));
    end
  end

endmodule

>>> hdl/ifs_fern_point_generator.sv
`timescale 1ns / 1ps
// Top level of the Barnsley fern point generator: configuration registers,
// the pick queue and the map engine. Depends on fern_pkg, fern_front and fern_back.

// Each accepted item is a random pick from 0 to 99 that chooses one of the
// four fern maps (weights 1, 7, 7 and 85); the map moves the stored point,
// which starts at the origin after reset, and the block returns one pixel
// for it, clamped to the image, with in_bounds low when clamping was needed.
// Picks go into a queue of QUEUE_DEPTH entries, so the input side keeps
// taking items while a pixel waits on the output, until the queue is full.
// The map engine takes the next item only as it places the current one,
// passing each through a multiply and a round-and-saturate stage for
// the point update, then a scaling multiply and a reciprocal divide stage,
// then the placement into the output register. image_width and
// image_height may only be written while no item is in flight.
module ifs_fern_point_generator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [fern_pkg::INDEX_W-1:0]      cfg_index,
  input  logic [fern_pkg::SIDE_W-1:0]       cfg_data,
  input  logic                              pick_valid,
  output logic                              pick_stall,
  input  logic [fern_pkg::PICK_W-1:0]       random_pick,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output logic [fern_pkg::PIXEL_W-1:0]      pixel_x,
  output logic [fern_pkg::PIXEL_W-1:0]      pixel_y,
  output logic                              in_bounds
);

  logic [fern_pkg::SIDE_W-1:0] image_width;
  logic [fern_pkg::SIDE_W-1:0] image_height;
  fern_pkg::pick_t             head;
  logic                        pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= fern_pkg::WIDTH_RESET;
      image_height <= fern_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fern_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        fern_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick classification and queue.
  fern_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pick_valid  (pick_valid),
    .pick_stall  (pick_stall),
    .random_pick (random_pick),
    .head        (head),
    .pop         (pop)
  );

  // Map engine and pixel output.
  fern_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .in_bounds    (in_bounds)
  );

endmodule
